// ===== rtl/audio_block_level_meter_macros.svh =====
// assertion macros for the audio block level meter checker
// used by abm_checker only; no other dependencies
`ifndef AUDIO_BLOCK_LEVEL_METER_MACROS_SVH
`define AUDIO_BLOCK_LEVEL_METER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ABM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level meter check failed");

// next-cycle implication, disabled while reset is low
`define ABM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level meter check failed");

`endif

// ===== rtl/abm_pkg.sv =====
// shared types and constants for the audio block level meter
// no dependencies
package abm_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 24;
    localparam int COUNT_W  = 14;
    localparam int SUM_W    = 59;
    localparam int SQUARE_W = 2 * SAMPLE_W;

    // block length limit and derived saturation points
    localparam int MAX_BLOCK     = 4096;
    localparam int COUNT_CAP_RAW = 2 * MAX_BLOCK;
    localparam int COUNT_CAP_INT = (COUNT_CAP_RAW > 16383) ? 16383 : COUNT_CAP_RAW;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(8388608);

    // divider and square root sizes
    localparam int QUO_W      = SUM_W + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_W     = QUO_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int MASK_W = 2;
    localparam logic [MASK_W-1:0]  MASK_RESET = 2'd3;
    localparam logic [LEVEL_W-1:0] CLIP_RESET = LEVEL_W'(4194304);
    localparam logic REG_CHANNEL_MASK   = 1'b0;
    localparam logic REG_CLIP_THRESHOLD = 1'b1;

    // channel select codes
    localparam logic CHAN_LEFT  = 1'b0;
    localparam logic CHAN_RIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_SQ_R,
        ST_ACC_R,
        ST_START,
        ST_DIV,
        ST_SQRT,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic square_en;
        logic square_sel;
        logic acc_en;
        logic acc_sel;
        logic arith_start;
        logic div_step;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/abm_cfg.sv =====
// configuration register file on an apb-style port
// depends on abm_pkg
module abm_cfg
    import abm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [MASK_W-1:0]   o_channel_mask,
    output logic [LEVEL_W-1:0]  o_clip_threshold
);

    logic [MASK_W-1:0]  r_channel_mask;
    logic [LEVEL_W-1:0] r_clip_threshold;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, decoded on the word address bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mask   <= MASK_RESET;
            r_clip_threshold <= CLIP_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CHANNEL_MASK:   r_channel_mask   <= pwdata[MASK_W-1:0];
                REG_CLIP_THRESHOLD: r_clip_threshold <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_CHANNEL_MASK:   prdata = DATA_W'(r_channel_mask);
            REG_CLIP_THRESHOLD: prdata = DATA_W'(r_clip_threshold);
            default:            prdata = '0;
        endcase
    end

    assign o_channel_mask   = r_channel_mask;
    assign o_clip_threshold = r_clip_threshold;

endmodule

// ===== rtl/abm_ctrl.sv =====
// sequencing state machine: per-sample fold, block-end divide and root, result hand-off
// depends on abm_pkg
module abm_ctrl
    import abm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_block_end,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic              r_end, n_end;
    logic [STEP_W-1:0] r_step, n_step;

    // state, block-end flag and iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_end   <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_SQ_L;
            ST_SQ_L:   n_state = ST_SQ_R;
            ST_SQ_R:   n_state = ST_ACC_R;
            ST_ACC_R:  n_state = r_end ? ST_START : ST_IDLE;
            ST_START:  n_state = i_status.cnt_zero ? ST_FINISH : ST_DIV;
            ST_DIV:    if (r_step == '0) n_state = ST_SQRT;
            ST_SQRT:   if (r_step == '0) n_state = ST_FINISH;
            ST_FINISH: if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // transaction flag and step counter
    always_comb begin
        n_end  = r_end;
        n_step = r_step;
        if (r_state == ST_IDLE && i_valid) begin
            n_end = i_block_end;
        end
        unique case (r_state)
            ST_START: n_step = STEP_W'(DIV_STEPS - 1);
            ST_DIV:   n_step = (r_step == '0) ? STEP_W'(SQRT_STEPS - 1) : r_step - 1'b1;
            ST_SQRT:  n_step = (r_step == '0) ? '0 : r_step - 1'b1;
            default:  ;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: o_cmd.capture = i_valid;
            ST_SQ_L: begin
                o_cmd.square_en  = 1'b1;
                o_cmd.square_sel = CHAN_LEFT;
            end
            ST_SQ_R: begin
                o_cmd.square_en  = 1'b1;
                o_cmd.square_sel = CHAN_RIGHT;
                o_cmd.acc_en     = 1'b1;
                o_cmd.acc_sel    = CHAN_LEFT;
            end
            ST_ACC_R: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_sel = CHAN_RIGHT;
            end
            ST_START:  o_cmd.arith_start = 1'b1;
            ST_DIV:    o_cmd.div_step    = 1'b1;
            ST_SQRT:   o_cmd.sqrt_step   = 1'b1;
            ST_FINISH: o_cmd.out_load    = i_status.out_free;
            default:   ;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/abm_dp.sv =====
// datapath: magnitudes, squarer, block accumulators, shift-subtract divider,
// digit-by-digit square root and result register; depends on abm_pkg
module abm_dp
    import abm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic [MASK_W-1:0]          i_channel_mask,
    input  logic [LEVEL_W-1:0]         i_clip_threshold,
    input  logic                       i_stall,
    output t_status                    o_status,
    output logic                       o_valid,
    output logic [LEVEL_W-1:0]         o_peak_level,
    output logic [LEVEL_W-1:0]         o_rms_level,
    output logic [COUNT_W-1:0]         o_clipped_count
);

    logic [LEVEL_W-1:0]  r_mag_l, r_mag_r;
    logic [SQUARE_W-1:0] r_square;
    logic [LEVEL_W-1:0]  r_peak;
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_clip, r_seen;
    logic [QUO_W-1:0]    r_quo;
    logic [COUNT_W-1:0]  r_rem;
    logic [SREM_W-1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_peak_out, r_rms_out;
    logic [COUNT_W-1:0]  r_clip_out;

    logic [LEVEL_W-1:0]  mag_l, mag_r, mag_sq, mag_acc;
    logic                fold_en;
    logic [SUM_W:0]      sum_wide;
    logic [COUNT_W:0]    div_trial;
    logic                div_bit;
    logic [SREM_W-1:0]   sqrt_rem, sqrt_trial;
    logic                sqrt_bit;
    logic [LEVEL_W-1:0]  rms_sat;
    logic                out_free;

    // magnitudes; the most negative sample gives 2^23, which still fits
    assign mag_l = i_left_sample[SAMPLE_W-1]  ? LEVEL_W'(-i_left_sample)  : LEVEL_W'(i_left_sample);
    assign mag_r = i_right_sample[SAMPLE_W-1] ? LEVEL_W'(-i_right_sample) : LEVEL_W'(i_right_sample);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mag_l <= mag_l;
            r_mag_r <= mag_r;
        end
    end

    // squarer, registered
    assign mag_sq = (i_cmd.square_sel == CHAN_RIGHT) ? r_mag_r : r_mag_l;

    always_ff @(posedge i_clk) begin
        if (i_cmd.square_en) begin
            r_square <= SQUARE_W'(mag_sq * mag_sq);
        end
    end

    // block accumulators with saturation
    assign mag_acc  = (i_cmd.acc_sel == CHAN_RIGHT) ? r_mag_r : r_mag_l;
    assign fold_en  = i_cmd.acc_en && i_channel_mask[i_cmd.acc_sel];
    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(r_square);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_sum  <= '0;
            r_clip <= '0;
            r_seen <= '0;
        end else if (i_cmd.out_load) begin
            r_peak <= '0;
            r_sum  <= '0;
            r_clip <= '0;
            r_seen <= '0;
        end else if (fold_en) begin
            if (mag_acc > r_peak) begin
                r_peak <= mag_acc;
            end
            r_sum <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            if (mag_acc > i_clip_threshold) begin
                r_clip <= (r_clip >= COUNT_CAP) ? COUNT_CAP : r_clip + 1'b1;
            end
            r_seen <= (r_seen >= COUNT_CAP) ? COUNT_CAP : r_seen + 1'b1;
        end
    end

    // restoring divide step: one quotient bit per cycle
    assign div_trial = {r_rem, r_quo[QUO_W-1]};
    assign div_bit   = (div_trial >= {1'b0, r_seen});

    // square root step: one root bit per cycle from two radicand bits
    assign sqrt_rem   = {r_srem[SREM_W-3:0], r_quo[QUO_W-1:QUO_W-2]};
    assign sqrt_trial = {r_root, 2'b01};
    assign sqrt_bit   = (sqrt_rem >= sqrt_trial);

    // quotient doubles as the root's radicand shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.arith_start) begin
            r_quo  <= {1'b0, r_sum};
            r_rem  <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], div_bit};
            r_rem <= div_bit ? COUNT_W'(div_trial - {1'b0, r_seen}) : div_trial[COUNT_W-1:0];
        end else if (i_cmd.sqrt_step) begin
            r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
            r_srem <= sqrt_bit ? sqrt_rem - sqrt_trial : sqrt_rem;
            r_root <= {r_root[ROOT_W-2:0], sqrt_bit};
        end
    end

    // result register
    assign out_free = !r_out_valid || !i_stall;
    assign rms_sat  = (r_root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : r_root[LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_peak_out <= r_peak;
            r_rms_out  <= rms_sat;
            r_clip_out <= r_clip;
        end
    end

    assign o_status.cnt_zero = (r_seen == '0);
    assign o_status.out_free = out_free;
    assign o_valid           = r_out_valid;
    assign o_peak_level      = r_peak_out;
    assign o_rms_level       = r_rms_out;
    assign o_clipped_count   = r_clip_out;

endmodule

// ===== rtl/audio_block_level_meter.sv =====
// top level of the stereo peak / rms / clip level meter
// depends on abm_pkg, abm_cfg, abm_ctrl, abm_dp
//
// Takes one Q2.22 left/right pair per transaction and folds the channels enabled in
// channel_mask into per-block peak, sum of squares, clip count and sample count. An
// ordinary pair steps through accept, square left, square right while folding left, and
// fold right, using the one shared 24x24 squarer. A pair with block_end set adds a
// set-up step, the bit-serial divider (sum over sample count) and the bit-serial square
// root, then a load of the result register; with no samples in the block the divide
// and root are skipped. The result register frees the input side, so the next pair is
// taken while a result still waits.
module audio_block_level_meter
    import abm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic                       i_block_end,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [LEVEL_W-1:0]         o_peak_level,
    output logic [LEVEL_W-1:0]         o_rms_level,
    output logic [COUNT_W-1:0]         o_clipped_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [MASK_W-1:0]  channel_mask;
    logic [LEVEL_W-1:0] clip_threshold;
    t_cmd               cmd;
    t_status            status;

    // configuration registers
    abm_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_channel_mask   (channel_mask),
        .o_clip_threshold (clip_threshold)
    );

    // sequencer
    abm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_block_end (i_block_end),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    // arithmetic and result register
    abm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_channel_mask   (channel_mask),
        .i_clip_threshold (clip_threshold),
        .i_stall          (i_stall),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_peak_level     (o_peak_level),
        .o_rms_level      (o_rms_level),
        .o_clipped_count  (o_clipped_count)
    );

endmodule

// ===== rtl/abm_checker.sv =====
// port-level checks for the level meter, bound to the top level
// depends on abm_pkg and audio_block_level_meter_macros.svh
`include "audio_block_level_meter_macros.svh"

module abm_checker
    import abm_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [LEVEL_W-1:0]         o_peak_level,
    input logic [LEVEL_W-1:0]         o_rms_level,
    input logic [COUNT_W-1:0]         o_clipped_count
);

    logic                               levels_in_range;
    logic [2*LEVEL_W+COUNT_W-1:0]       result_bus;

    assign levels_in_range = (o_peak_level <= LEVEL_MAX) && (o_rms_level <= LEVEL_MAX)
                             && (o_clipped_count <= COUNT_CAP);
    assign result_bus      = {o_peak_level, o_rms_level, o_clipped_count};

    // one pair at a time: the input side closes right after a transaction
    `ABM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a result appears only as the sequencer returns to idle
    `ABM_ASSERT_NOW(a_result_at_idle, i_clk, i_rst_n, $rose(o_valid), !o_stall)

    // levels and count stay within their saturation points
    `ABM_ASSERT_NOW(a_result_range, i_clk, i_rst_n, o_valid, levels_in_range)

    // a stalled result holds
    `ABM_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(result_bus))

endmodule

bind audio_block_level_meter abm_checker u_abm_checker (.*);
